/* src/mlfq_pkg.sv */
// Shared types and constants for the feedback-queue scheduler.
package mlfq_pkg;

  localparam int MAX_PROCS_DEF  = 16;
  localparam int BURST_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 16;
  localparam int ID_BITS        = 4;
  localparam int LEVEL_BITS     = 2;
  localparam int SLICE_BITS     = 8;
  localparam int AGE_BITS       = 15;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = 15;

  localparam logic [CFG_ADDR_BITS-1:0] REG_QUANTUM_ONE = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_QUANTUM_TWO = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_AGING       = 2'd2;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [SLICE_BITS-1:0] QUANTUM_ONE_RESET = 8'd5;
  localparam logic [SLICE_BITS-1:0] QUANTUM_TWO_RESET = 8'd8;
  localparam logic [AGE_BITS-1:0]   AGING_RESET       = 15'd40;

  typedef struct packed {
    logic                  command;
    logic [ID_BITS-1:0]    process_id;
    logic [15:0]           burst_length;
  } in_word_t;

  typedef struct packed {
    logic                  run_valid;
    logic [ID_BITS-1:0]    run_id;
    logic [LEVEL_BITS-1:0] run_level;
    logic                  finish_valid;
    logic [ID_BITS-1:0]    finish_id;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AGE_RD,
    ST_AGE_ID,
    ST_AGE_CHK,
    ST_RUN_RD,
    ST_RUN_CHK,
    ST_DISP_RD,
    ST_DISP,
    ST_BURST_RD,
    ST_BURST_WR,
    ST_OUT
  } state_t;

endpackage

/* src/mlfq_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/multilevel_feedback_queue_scheduler_unit.sv */
// Top level of the three-level feedback-queue scheduler.
// Usage: one input channel (in_valid/in_ready/in_word) carries arrive and
// tick words; one output channel (out_valid/out_ready/out_word) returns one
// result word per input word. An arrive word yields an all-zero result.
// A sequencer walks each tick through aging, retire/demote, dispatch or
// preempt and the burst update, sharing one queue RAM port and one
// per-id RAM port for bursts and wait stamps. The result word is offered
// in the ST_OUT state.
// in_ready is low while a word is in work and while a result waits.
// Configuration writes (cfg_we/cfg_index/cfg_data) go straight into the config registers.
// Synchronous reset clears counts, heads, runner state, time and config
// to their reset values; the RAMs keep their contents.
// When the receiver stalls, the result holds and no new word is taken.
module multilevel_feedback_queue_scheduler_unit
  import mlfq_pkg::*;
#(
  parameter int MAX_PROCS  = MAX_PROCS_DEF,
  parameter int BURST_BITS = BURST_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_word_t                 in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_word_t                out_word,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PB   = $clog2(MAX_PROCS);
  localparam int CB   = $clog2(MAX_PROCS + 1);
  localparam int QD   = 3 << PB;
  localparam int QA   = PB + 2;
  localparam int IDS  = 1 << ID_BITS;
  localparam int DW   = BURST_BITS + TIME_BITS;

  logic [SLICE_BITS-1:0] quantum_one, quantum_two;
  logic [AGE_BITS-1:0]   aging_limit;

  state_t state, state_next;
  logic [PB-1:0]         heads  [3];
  logic [CB-1:0]         counts [3];
  logic [ID_BITS-1:0]    runner_id;
  logic [LEVEL_BITS-1:0] runner_level;
  logic                  runner_busy;
  logic [SLICE_BITS-1:0] slice_used;
  logic [TIME_BITS-1:0]  time_now;
  logic [LEVEL_BITS-1:0] age_lvl;
  logic [ID_BITS-1:0]    cur_id;
  out_word_t             res;

  // queue RAM
  logic          q_we;
  logic [QA-1:0] q_waddr, q_raddr;
  logic [ID_BITS-1:0] q_wdata, q_rdata;
  // per-id RAM: {burst, stamp}
  logic          d_we;
  logic [ID_BITS-1:0] d_waddr, d_raddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic [BURST_BITS-1:0] r_burst;
  logic [TIME_BITS-1:0]  r_stamp;

  mlfq_ram #(.WIDTH(ID_BITS), .DEPTH(QD)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );
  mlfq_ram #(.WIDTH(DW), .DEPTH(IDS)) u_proc (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  assign r_burst = d_rdata[DW-1:TIME_BITS];
  assign r_stamp = d_rdata[TIME_BITS-1:0];

  function automatic logic [QA-1:0] qaddr(input logic [LEVEL_BITS-1:0] l,
                                          input logic [PB-1:0] p);
    return {l, p};
  endfunction

  function automatic logic [PB-1:0] tail(input logic [PB-1:0] h,
                                         input logic [CB-1:0] c);
    logic [CB:0] s;
    logic [CB:0] m;
    m = (CB+1)'(MAX_PROCS);
    s = (CB+1)'(h) + (CB+1)'(c);
    if (s >= m) begin
      s = s - m;
    end
    return PB'(s);
  endfunction

  function automatic logic [PB-1:0] inc(input logic [PB-1:0] h);
    return (h == PB'(MAX_PROCS - 1)) ? '0 : h + 1'b1;
  endfunction

  // combinational decisions
  logic [TIME_BITS-1:0]  waited;
  logic                  age_go;
  logic                  retire, demote;
  logic [SLICE_BITS-1:0] q_cur;
  logic                  any_q;
  logic [LEVEL_BITS-1:0] hi_lvl;
  logic                  preempt;
  logic [LEVEL_BITS-1:0] disp_lvl;
  logic                  total_ok;

  always_comb begin
    waited = time_now - r_stamp;
    age_go = (TIME_BITS > AGE_BITS) ? (waited >= TIME_BITS'(aging_limit))
                                    : (AGE_BITS'(waited) >= aging_limit);
    q_cur  = (runner_level == 2'd0) ? quantum_one : quantum_two;
    retire = runner_busy && (r_burst == '0);
    demote = runner_busy && !retire && (runner_level != 2'd2) && (slice_used >= q_cur);
    any_q  = (counts[0] != '0) || (counts[1] != '0) || (counts[2] != '0);
    hi_lvl = (counts[0] != '0) ? 2'd0 : ((counts[1] != '0) ? 2'd1 : 2'd2);
    preempt = runner_busy && ((runner_level != 2'd0 && counts[0] != '0) ||
                              (runner_level == 2'd2 && counts[1] != '0));
    disp_lvl = hi_lvl;
    total_ok = ((CB+2)'(counts[0]) + (CB+2)'(counts[1]) + (CB+2)'(counts[2]) +
                (CB+2)'(runner_busy)) < (CB+2)'(MAX_PROCS);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = (in_word.command == CMD_TICK) ? ST_AGE_RD : ST_OUT;
      ST_AGE_RD:   if (counts[age_lvl] == '0) begin
                     state_next = (age_lvl == 2'd2) ? ST_RUN_RD : ST_AGE_RD;
                   end else begin
                     state_next = ST_AGE_ID;
                   end
      ST_AGE_ID:   state_next = ST_AGE_CHK;
      ST_AGE_CHK:  state_next = (age_go || age_lvl == 2'd1) ? ST_AGE_RD : ST_RUN_RD;
      ST_RUN_RD:   state_next = runner_busy ? ST_RUN_CHK : ST_DISP_RD;
      ST_RUN_CHK:  state_next = ST_DISP_RD;
      ST_DISP_RD:  state_next = ((!runner_busy && any_q) || preempt) ? ST_DISP : ST_BURST_RD;
      ST_DISP:     state_next = ST_BURST_RD;
      ST_BURST_RD: state_next = runner_busy ? ST_BURST_WR : ST_OUT;
      ST_BURST_WR: state_next = ST_OUT;
      ST_OUT:      if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
    d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_word.command == CMD_ARRIVE && total_ok) begin
          q_we = 1'b1; q_waddr = qaddr(2'd0, tail(heads[0], counts[0]));
          q_wdata = in_word.process_id;
          d_we = 1'b1; d_waddr = in_word.process_id;
          d_wdata = {BURST_BITS'(in_word.burst_length), time_now};
        end
      end
      ST_AGE_RD: begin
        q_raddr = qaddr(age_lvl, heads[age_lvl]);
      end
      ST_AGE_ID: begin
        d_raddr = q_rdata;
      end
      ST_AGE_CHK: begin
        d_raddr = cur_id;
        if (age_go) begin
          q_we = 1'b1; q_waddr = qaddr(age_lvl - 1'b1,
                                       tail(heads[age_lvl - 1'b1], counts[age_lvl - 1'b1]));
          q_wdata = cur_id;
          d_we = 1'b1; d_waddr = cur_id; d_wdata = {r_burst, time_now};
        end
      end
      ST_RUN_RD: d_raddr = runner_id;
      ST_RUN_CHK: begin
        d_raddr = runner_id;
        if (demote) begin
          q_we = 1'b1; q_waddr = qaddr(runner_level + 1'b1,
                                       tail(heads[runner_level + 1'b1],
                                            counts[runner_level + 1'b1]));
          q_wdata = runner_id;
          d_we = 1'b1; d_waddr = runner_id; d_wdata = {r_burst, time_now};
        end
      end
      ST_DISP_RD: begin
        q_raddr = qaddr(disp_lvl, heads[disp_lvl]);
        d_raddr = runner_id;
      end
      ST_DISP: begin
        if (runner_busy) begin
          q_we = 1'b1; q_waddr = qaddr(runner_level,
                                       tail(heads[runner_level], counts[runner_level]));
          q_wdata = runner_id;
          d_we = 1'b1; d_waddr = runner_id; d_wdata = {r_burst, time_now};
        end
      end
      ST_BURST_RD: d_raddr = runner_id;
      ST_BURST_WR: begin
        if (r_burst != '0) begin
          d_we = 1'b1; d_waddr = runner_id; d_wdata = {r_burst - 1'b1, r_stamp};
        end
      end
      default: ;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    out_word  = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_one <= QUANTUM_ONE_RESET;
      quantum_two <= QUANTUM_TWO_RESET;
      aging_limit <= AGING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUANTUM_ONE: quantum_one <= cfg_data[SLICE_BITS-1:0];
        REG_QUANTUM_TWO: quantum_two <= cfg_data[SLICE_BITS-1:0];
        REG_AGING:       aging_limit <= cfg_data[AGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < 3; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
      runner_id    <= '0;
      runner_level <= '0;
      runner_busy  <= 1'b0;
      slice_used   <= '0;
      time_now     <= '0;
      age_lvl      <= 2'd1;
      cur_id       <= '0;
      res          <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            res     <= '0;
            age_lvl <= 2'd1;
            if (in_word.command == CMD_ARRIVE && total_ok) begin
              counts[0] <= counts[0] + 1'b1;
            end
          end
        end
        ST_AGE_RD: begin
          if (counts[age_lvl] == '0) begin
            age_lvl <= age_lvl + 1'b1;
          end
        end
        ST_AGE_ID: begin
          cur_id <= q_rdata;
        end
        ST_AGE_CHK: begin
          if (age_go) begin
            heads[age_lvl]  <= inc(heads[age_lvl]);
            counts[age_lvl] <= counts[age_lvl] - 1'b1;
            counts[age_lvl - 1'b1] <= counts[age_lvl - 1'b1] + 1'b1;
          end else begin
            age_lvl <= age_lvl + 1'b1;
          end
        end
        ST_RUN_CHK: begin
          if (retire) begin
            res.finish_valid <= 1'b1;
            res.finish_id    <= runner_id;
            runner_busy      <= 1'b0;
          end else if (demote) begin
            counts[runner_level + 1'b1] <= counts[runner_level + 1'b1] + 1'b1;
            runner_busy <= 1'b0;
          end
        end
        ST_DISP: begin
          if (runner_busy) begin
            counts[runner_level] <= counts[runner_level] + 1'b1;
          end
          heads[disp_lvl]  <= inc(heads[disp_lvl]);
          counts[disp_lvl] <= counts[disp_lvl] - 1'b1;
          runner_id    <= q_rdata;
          runner_level <= disp_lvl;
          runner_busy  <= 1'b1;
          slice_used   <= '0;
        end
        ST_BURST_RD: begin
          if (runner_busy) begin
            res.run_valid <= 1'b1;
            res.run_id    <= runner_id;
            res.run_level <= runner_level;
            if (slice_used != '1) begin
              slice_used <= slice_used + 1'b1;
            end
          end
          time_now <= time_now + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
